>>> rtl/depth_width_limited_graph_search_unit_defines.svh
// Assertion macros shared by the graph search unit's RTL files.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef DEPTH_WIDTH_LIMITED_GRAPH_SEARCH_UNIT_DEFINES_SVH
`define DEPTH_WIDTH_LIMITED_GRAPH_SEARCH_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWLS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DWLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dwls_pkg.sv
// Shared types and constants for the depth and width limited graph search unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package dwls_pkg;

  localparam int NUM_VERTICES = 16;
  localparam int IDX_W        = $clog2(NUM_VERTICES);
  localparam int LVL_W        = $clog2(NUM_VERTICES + 1);

  // Fixed field widths of the item formats.
  localparam int VTX_W   = 4;
  localparam int DEPTH_W = 5;
  localparam int BEAM_W  = 4;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SEARCH   = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [VTX_W-1:0]   vertex_a;
    logic [VTX_W-1:0]   vertex_b;
    logic [DEPTH_W-1:0] depth_limit;
    logic [BEAM_W-1:0]  beam_width;
  } in_item_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic edge_wr;
    logic search_init;
    logic pop;
    logic load_scan;
    logic scan_inc;
    logic take_hit;
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic is_search;
    logic start_ok;
    logic level_zero;
    logic expand_blocked;
    logic scan_end;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/dwls_dp.sv
// Datapath of the graph search unit: adjacency matrix, visited bits, walk stack,
// neighbor scan counter and output register. Depends on dwls_pkg and the defines header.
`include "depth_width_limited_graph_search_unit_defines.svh"

module dwls_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dwls_pkg::in_item_t   in_data,
  input  dwls_pkg::dp_cmd_t    cmd,
  output dwls_pkg::dp_status_t status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output dwls_pkg::out_item_t  out_data
);

  logic [dwls_pkg::NUM_VERTICES-1:0] adj_r [dwls_pkg::NUM_VERTICES];
  logic [dwls_pkg::NUM_VERTICES-1:0] visited_r;
  logic [dwls_pkg::IDX_W-1:0]        stk_vtx_r  [dwls_pkg::NUM_VERTICES];
  logic [dwls_pkg::LVL_W-1:0]        stk_scan_r [dwls_pkg::NUM_VERTICES];
  logic [dwls_pkg::BEAM_W-1:0]       stk_cnt_r  [dwls_pkg::NUM_VERTICES];
  logic [dwls_pkg::LVL_W-1:0]        level_r;
  logic [dwls_pkg::LVL_W-1:0]        scan_r;
  logic [dwls_pkg::DEPTH_W-1:0]      depth_r;
  logic [dwls_pkg::BEAM_W-1:0]       width_r;
  logic [dwls_pkg::IDX_W-1:0]        pend_r;
  logic                              out_valid_r;
  logic [dwls_pkg::VTX_W-1:0]        out_vtx_r;
  logic                              out_last_r;

  logic                         a_ok;
  logic                         b_ok;
  logic [dwls_pkg::IDX_W-1:0]   a_idx;
  logic [dwls_pkg::IDX_W-1:0]   b_idx;
  logic [dwls_pkg::LVL_W-1:0]   lvl_m1;
  logic [dwls_pkg::IDX_W-1:0]   top_idx;
  logic [dwls_pkg::IDX_W-1:0]   push_idx;
  logic [dwls_pkg::IDX_W-1:0]   cur_vtx;
  logic [dwls_pkg::IDX_W-1:0]   scan_idx;
  logic                         scan_end;
  logic                         hit;
  logic                         out_free;
  logic                         can_push;

  assign a_ok     = int'(in_data.vertex_a) < dwls_pkg::NUM_VERTICES;
  assign b_ok     = int'(in_data.vertex_b) < dwls_pkg::NUM_VERTICES;
  assign a_idx    = dwls_pkg::IDX_W'(in_data.vertex_a);
  assign b_idx    = dwls_pkg::IDX_W'(in_data.vertex_b);
  assign lvl_m1   = level_r - dwls_pkg::LVL_W'(1);
  assign top_idx  = lvl_m1[dwls_pkg::IDX_W-1:0];
  assign push_idx = level_r[dwls_pkg::IDX_W-1:0];
  assign can_push = int'(level_r) < dwls_pkg::NUM_VERTICES;
  assign cur_vtx  = stk_vtx_r[top_idx];
  assign scan_idx = scan_r[dwls_pkg::IDX_W-1:0];
  assign scan_end = int'(scan_r) >= dwls_pkg::NUM_VERTICES;
  assign hit      = !scan_end && adj_r[cur_vtx][scan_idx] && !visited_r[scan_idx];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    status.is_search      = in_data.operation == dwls_pkg::OP_SEARCH;
    status.start_ok       = a_ok;
    status.level_zero     = level_r == '0;
    // The top may only expand below the depth limit and under beam_width children.
    status.expand_blocked = (int'(level_r) >= int'(depth_r)) ||
                            (stk_cnt_r[top_idx] >= width_r);
    status.scan_end       = scan_end;
    status.hit            = hit;
    status.out_free       = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dwls_pkg::NUM_VERTICES; i++) begin
        adj_r[i] <= '0;
      end
      visited_r   <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.edge_wr && a_ok && b_ok) begin
        adj_r[a_idx][b_idx] <= 1'b1;
        adj_r[b_idx][a_idx] <= 1'b1;
      end
      if (cmd.search_init) begin
        visited_r <= dwls_pkg::NUM_VERTICES'(1) << a_idx;
        level_r   <= dwls_pkg::LVL_W'(1);
      end
      if (cmd.pop) begin
        level_r <= lvl_m1;
      end
      if (cmd.take_hit) begin
        visited_r[scan_idx] <= 1'b1;
        if (can_push) begin
          level_r <= level_r + dwls_pkg::LVL_W'(1);
        end
      end
      if (cmd.take_hit || cmd.emit_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      stk_vtx_r[0]  <= a_idx;
      stk_scan_r[0] <= '0;
      stk_cnt_r[0]  <= '0;
      pend_r        <= a_idx;
      depth_r       <= (in_data.depth_limit == '0) ? dwls_pkg::DEPTH_W'(1)
                                                   : in_data.depth_limit;
      width_r       <= in_data.beam_width;
    end
    if (cmd.load_scan) begin
      scan_r <= stk_scan_r[top_idx];
    end
    if (cmd.scan_inc) begin
      scan_r <= scan_r + dwls_pkg::LVL_W'(1);
    end
    // The previous vertex is known not to be last once another one is found.
    if (cmd.take_hit) begin
      stk_scan_r[top_idx] <= scan_r + dwls_pkg::LVL_W'(1);
      stk_cnt_r[top_idx]  <= stk_cnt_r[top_idx] + dwls_pkg::BEAM_W'(1);
      if (can_push) begin
        stk_vtx_r[push_idx]  <= scan_idx;
        stk_scan_r[push_idx] <= '0;
        stk_cnt_r[push_idx]  <= '0;
      end
      out_vtx_r  <= dwls_pkg::VTX_W'(pend_r);
      out_last_r <= 1'b0;
      pend_r     <= scan_idx;
    end
    if (cmd.emit_last) begin
      out_vtx_r  <= dwls_pkg::VTX_W'(pend_r);
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data.vertex = out_vtx_r;
  assign out_data.last   = out_last_r;

  `DWLS_ASSERT_SAME(a_level_bound, 1'b1, int'(level_r) <= dwls_pkg::NUM_VERTICES, "stack level overflow")
  `DWLS_ASSERT_SAME(a_hit_needs_room, cmd.take_hit, out_free, "result taken while output register busy")
  `DWLS_ASSERT_NEXT(a_init_one_visit, cmd.search_init, $onehot(visited_r) && level_r == dwls_pkg::LVL_W'(1), "search start state wrong")

endmodule

>>> rtl/dwls_ctrl.sv
// Controller of the graph search unit: sequences edge writes, stack steps,
// neighbor scans and result hand-off. Depends on dwls_pkg and the defines header.
`include "depth_width_limited_graph_search_unit_defines.svh"

module dwls_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dwls_pkg::dp_status_t status,
  output dwls_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_TOP    = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = state_r != S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!status.is_search) begin
            cmd.edge_wr = 1'b1;
          end else if (status.start_ok) begin
            cmd.search_init = 1'b1;
            state_nxt       = S_TOP;
          end
        end
      end
      S_TOP: begin
        if (status.level_zero) begin
          state_nxt = S_FINISH;
        end else if (status.expand_blocked) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.load_scan = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_end) begin
          cmd.pop   = 1'b1;
          state_nxt = S_TOP;
        end else if (status.hit) begin
          // Hold on the hit until the previous result can move out.
          if (status.out_free) begin
            cmd.take_hit = 1'b1;
            state_nxt    = S_TOP;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `DWLS_ASSERT_NEXT(a_finish_to_idle, state_r == S_FINISH && status.out_free, state_r == S_IDLE, "finish did not return to idle")
  `DWLS_ASSERT_SAME(a_scan_live_stack, state_r == S_SCAN, !status.level_zero, "scan with empty stack")

endmodule

>>> rtl/depth_width_limited_graph_search_unit.sv
// Depth and width limited graph search unit: an add-edge item yields nothing; a
// search item walks the stored graph depth first and returns one item per visited
// vertex, the final one marked last. The neighbor scan tests one adjacency bit per
// cycle, but holds on a hit while the previous result waits in a stalled output
// register. No new item is taken until the current search has loaded its last
// result into the output register.
// Depends on dwls_pkg, dwls_ctrl and dwls_dp.

module depth_width_limited_graph_search_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dwls_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dwls_pkg::out_item_t out_data
);

  dwls_pkg::dp_cmd_t    cmd;
  dwls_pkg::dp_status_t status;

  dwls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dwls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
